[hdl/crcdf_pkg.sv]
// Package for the CRC-16 frame deframer: phase and event codes, queue entry type,
// register indexes, reset values and the bytewise reflected CRC update.
// No dependencies.
`default_nettype none

package crcdf_pkg;

    localparam int PAYLOAD_MAX_DEF = 64;

    // queue between the parser and the delivery side
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // configuration register indexes
    localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] REG_MAX_PAYLOAD   = 3'd2;
    localparam logic [2:0] REG_CRC_POLY      = 3'd3;
    localparam logic [2:0] REG_CRC_INIT      = 3'd4;

    // register reset values
    localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
    localparam logic [6:0]  MAX_PAYLOAD_RST   = 7'd64;
    localparam logic [15:0] CRC_POLY_RST      = 16'hA001;
    localparam logic [15:0] CRC_INIT_RST      = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRCLO,
        PH_CRCHI
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_LEN_ERR = 2'd2,
        EV_CRC_ERR = 2'd3
    } event_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // one classified frame outcome, counters already updated
    typedef struct packed {
        event_t      ev;
        logic [7:0]  ftype;
        logic [6:0]  plen;
        logic [31:0] good;
        logic [31:0] len_err;
        logic [31:0] crc_err;
        logic [31:0] resync;
    } cmd_t;

    // reflected, LSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/crcdf_store.sv]
// Payload buffer of the deframer: one write port from the parser, one
// registered read port for delivery. Depends on nothing but its parameter.
`default_nettype none

module crcdf_store #(
    parameter int PAYLOAD_MAX = 64
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [7:0]            wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic [7:0]                 rd_data
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [7:0] mem [PAYLOAD_MAX];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/crcdf_front.sv]
// Parser side of the deframer: configuration registers, header hunt, length
// check, CRC and counters; pushes one outcome per frame. Uses crcdf_pkg.
`default_nettype none

module crcdf_front #(
    parameter int PAYLOAD_MAX = crcdf_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 q_full,
    output logic                      q_push,
    output crcdf_pkg::cmd_t           q_cmd,
    input  wire logic                 payload_done,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [7:0]                wr_data,
    output logic                      pending
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam logic [6:0] PMAX = 7'(PAYLOAD_MAX);

    logic [7:0]  header_first_reg, header_second_reg;
    logic [6:0]  max_payload_reg;
    logic [15:0] crc_poly_reg, crc_init_reg;

    crcdf_pkg::phase_t phase_reg, phase_next;
    logic [6:0]  frame_length_reg, frame_length_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [6:0]  bytes_taken_reg, bytes_taken_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] len_err_reg, len_err_next;
    logic [31:0] crc_err_reg, crc_err_next;
    logic [31:0] resync_reg, resync_next;
    logic        pending_reg, pending_next;

    logic              accept;
    logic [6:0]        maxp;
    logic [6:0]        plen;
    logic [6:0]        bt_inc;
    logic [15:0]       crc_upd;
    crcdf_pkg::event_t push_ev;
    logic [7:0]        push_type;
    logic [6:0]        push_plen;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && !(phase_reg == crcdf_pkg::PH_DATA && pending_reg);
    assign accept    = s_tvalid && s_tready;
    assign pending   = pending_reg;

    assign maxp    = (max_payload_reg > PMAX) ? PMAX : max_payload_reg;
    assign bt_inc  = bytes_taken_reg + 7'd1;
    assign plen    = ((frame_length_reg - 7'd1) > PMAX) ? PMAX : (frame_length_reg - 7'd1);
    assign crc_upd = crcdf_pkg::crc_byte(running_crc_reg, rx_byte, crc_poly_reg);

    assign wr_addr = bytes_taken_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        held_type_next    = held_type_reg;
        bytes_taken_next  = bytes_taken_reg;
        running_crc_next  = running_crc_reg;
        crc_low_next      = crc_low_reg;
        good_next         = good_reg;
        len_err_next      = len_err_reg;
        crc_err_next      = crc_err_reg;
        resync_next       = resync_reg;
        q_push            = 1'b0;
        wr_en             = 1'b0;
        push_ev           = crcdf_pkg::EV_LEN_ERR;
        push_type         = 8'd0;
        push_plen         = 7'd0;

        if (accept)
        begin
            case (phase_reg)
                crcdf_pkg::PH_HUNT1:
                begin
                    if (rx_byte == header_first_reg)
                    begin
                        phase_next = crcdf_pkg::PH_HUNT2;
                    end
                end
                crcdf_pkg::PH_HUNT2:
                begin
                    if (rx_byte == header_second_reg)
                    begin
                        running_crc_next = crc_init_reg;
                        phase_next       = crcdf_pkg::PH_LEN;
                    end
                    else if (rx_byte != header_first_reg)
                    begin
                        phase_next = crcdf_pkg::PH_HUNT1;
                    end
                end
                crcdf_pkg::PH_LEN:
                begin
                    if (rx_byte == 8'd0 || {1'b0, rx_byte} > ({2'b00, maxp} + 9'd1))
                    begin
                        len_err_next = len_err_reg + 32'd1;
                        resync_next  = resync_reg + 32'd1;
                        phase_next   = crcdf_pkg::PH_HUNT1;
                        q_push       = 1'b1;
                        push_ev      = crcdf_pkg::EV_LEN_ERR;
                    end
                    else
                    begin
                        frame_length_next = rx_byte[6:0];
                        running_crc_next  = crc_upd;
                        phase_next        = crcdf_pkg::PH_TYPE;
                    end
                end
                crcdf_pkg::PH_TYPE:
                begin
                    held_type_next   = rx_byte;
                    running_crc_next = crc_upd;
                    bytes_taken_next = 7'd0;
                    phase_next       = (frame_length_reg <= 7'd1) ? crcdf_pkg::PH_CRCLO
                                                                  : crcdf_pkg::PH_DATA;
                end
                crcdf_pkg::PH_DATA:
                begin
                    wr_en            = (bytes_taken_reg < PMAX);
                    bytes_taken_next = bt_inc;
                    running_crc_next = crc_upd;
                    if (({1'b0, bt_inc} + 8'd1) >= {1'b0, frame_length_reg})
                    begin
                        phase_next = crcdf_pkg::PH_CRCLO;
                    end
                end
                crcdf_pkg::PH_CRCLO:
                begin
                    crc_low_next = rx_byte;
                    phase_next   = crcdf_pkg::PH_CRCHI;
                end
                crcdf_pkg::PH_CRCHI:
                begin
                    phase_next = crcdf_pkg::PH_HUNT1;
                    q_push     = 1'b1;
                    if ({rx_byte, crc_low_reg} == running_crc_reg)
                    begin
                        good_next = good_reg + 32'd1;
                        push_type = held_type_reg;
                        if (plen == 7'd0)
                        begin
                            push_ev = crcdf_pkg::EV_EMPTY;
                        end
                        else
                        begin
                            push_ev   = crcdf_pkg::EV_PAYLOAD;
                            push_plen = plen;
                        end
                    end
                    else
                    begin
                        crc_err_next = crc_err_reg + 32'd1;
                        resync_next  = resync_reg + 32'd1;
                        push_ev      = crcdf_pkg::EV_CRC_ERR;
                    end
                end
                default:
                begin
                    // unused phase code: force a resync
                    resync_next = resync_reg + 32'd1;
                    phase_next  = crcdf_pkg::PH_HUNT1;
                end
            endcase
        end

        pending_next = pending_reg;
        if (payload_done)
        begin
            pending_next = 1'b0;
        end
        if (q_push && push_ev == crcdf_pkg::EV_PAYLOAD)
        begin
            pending_next = 1'b1;
        end

        q_cmd.ev      = push_ev;
        q_cmd.ftype   = push_type;
        q_cmd.plen    = push_plen;
        q_cmd.good    = good_next;
        q_cmd.len_err = len_err_next;
        q_cmd.crc_err = crc_err_next;
        q_cmd.resync  = resync_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= crcdf_pkg::PH_HUNT1;
            frame_length_reg <= 7'd0;
            held_type_reg    <= 8'd0;
            bytes_taken_reg  <= 7'd0;
            running_crc_reg  <= crcdf_pkg::CRC_INIT_RST;
            crc_low_reg      <= 8'd0;
            good_reg         <= 32'd0;
            len_err_reg      <= 32'd0;
            crc_err_reg      <= 32'd0;
            resync_reg       <= 32'd0;
            pending_reg      <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            held_type_reg    <= held_type_next;
            bytes_taken_reg  <= bytes_taken_next;
            running_crc_reg  <= running_crc_next;
            crc_low_reg      <= crc_low_next;
            good_reg         <= good_next;
            len_err_reg      <= len_err_next;
            crc_err_reg      <= crc_err_next;
            resync_reg       <= resync_next;
            pending_reg      <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= crcdf_pkg::HEADER_FIRST_RST;
            header_second_reg <= crcdf_pkg::HEADER_SECOND_RST;
            max_payload_reg   <= crcdf_pkg::MAX_PAYLOAD_RST;
            crc_poly_reg      <= crcdf_pkg::CRC_POLY_RST;
            crc_init_reg      <= crcdf_pkg::CRC_INIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crcdf_pkg::REG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                crcdf_pkg::REG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                crcdf_pkg::REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[6:0];
                crcdf_pkg::REG_CRC_POLY:      crc_poly_reg      <= cfg_data;
                crcdf_pkg::REG_CRC_INIT:      crc_init_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/crcdf_queue.sv]
// Two-entry queue of frame outcomes between parser and delivery side.
// Uses crcdf_pkg for the entry type and depth.
`default_nettype none

module crcdf_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  crcdf_pkg::cmd_t      cmd_in,
    output logic                 full,
    output logic                 empty,
    input  wire logic            pop,
    output crcdf_pkg::cmd_t      cmd_out
);

    crcdf_pkg::cmd_t                   entry_reg [crcdf_pkg::QUEUE_DEPTH];
    logic [crcdf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [crcdf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [crcdf_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                              do_push, do_pop;

    assign full    = (count_reg == crcdf_pkg::QCNT_W'(crcdf_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/crcdf_back.sv]
// Delivery side of the deframer: takes outcomes from the queue, walks the
// payload buffer and drives the output register. Uses crcdf_pkg.
`default_nettype none

module crcdf_back #(
    parameter int PAYLOAD_MAX = crcdf_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  crcdf_pkg::cmd_t           q_cmd,
    output logic                      q_pop,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  wire logic [7:0]           rd_data,
    output logic                      payload_done,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [159:0]              m_tdata,
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    crcdf_pkg::back_state_t state_reg, state_next;
    crcdf_pkg::cmd_t        cmd_reg, cmd_next;
    logic [6:0]             idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    crcdf_pkg::event_t      out_ev_reg;
    logic [7:0]             out_type_reg;
    logic [5:0]             out_idx_reg;
    logic [6:0]             out_plen_reg;
    logic                   out_last_reg;
    logic [31:0]            out_good_reg, out_lerr_reg, out_cerr_reg, out_rsync_reg;
    logic                   load_ok, emit, is_last;
    logic [7:0]             out_data;

    assign load_ok = !out_valid_reg || m_tready;
    assign is_last = (cmd_reg.ev != crcdf_pkg::EV_PAYLOAD) || ((idx_reg + 7'd1) == cmd_reg.plen);
    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        case (state_reg)
            crcdf_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    idx_next   = 7'd0;
                    state_next = crcdf_pkg::BK_RUN;
                end
            end
            crcdf_pkg::BK_RUN:
            begin
                if (load_ok)
                begin
                    emit = 1'b1;
                    if (is_last)
                    begin
                        state_next = crcdf_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                    end
                end
            end
            default:
            begin
                state_next = crcdf_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        rd_en        = emit && (cmd_reg.ev == crcdf_pkg::EV_PAYLOAD);
        payload_done = rd_en && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crcdf_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (emit)
        begin
            out_ev_reg    <= cmd_reg.ev;
            out_type_reg  <= cmd_reg.ftype;
            out_idx_reg   <= idx_reg[5:0];
            out_plen_reg  <= cmd_reg.plen;
            out_last_reg  <= is_last;
            out_good_reg  <= cmd_reg.good;
            out_lerr_reg  <= cmd_reg.len_err;
            out_cerr_reg  <= cmd_reg.crc_err;
            out_rsync_reg <= cmd_reg.resync;
        end
    end

    // read data lands with the output register; mask it for non-payload events
    assign out_data = (out_ev_reg == crcdf_pkg::EV_PAYLOAD) ? rd_data : 8'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_rsync_reg, out_cerr_reg, out_lerr_reg, out_good_reg,
                       out_plen_reg, out_idx_reg, out_data, out_type_reg};

endmodule

`default_nettype wire

[hdl/crc16_frame_deframer_core.sv]
// CRC-16 length-prefixed frame deframer, top level.
// Throughput: one received byte per cycle while the outcome queue has room; the parser also
// holds off on payload bytes while the previous frame's payload is still being delivered
// from the shared buffer. Results: one per cycle while m_tready is high, with an idle state
// between frame outcomes in which the next one is fetched from the queue.
// Reset (rst_n, async, active low): control, counters and configuration registers to defaults;
// buffer contents stay undefined and need no clearing pass.
`default_nettype none

module crc16_frame_deframer_core #(
    parameter int PAYLOAD_MAX = crcdf_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // received bytes
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,      // [7:0] rx_byte
    // configuration writes
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    // results
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [159:0]       m_tdata,      // [7:0] frame_type, [15:8] data_byte,
                                             // [21:16] byte_index, [28:22] payload_length,
                                             // [60:29] good_frames, [92:61] length_errors,
                                             // [124:93] checksum_errors,
                                             // [156:125] resync_total, [159:157] zero
    output logic [1:0]         m_tuser,      // [1:0] event_res
    output logic               m_tlast       // last
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // parser to queue
    logic            q_push, q_full, q_empty, q_pop;
    crcdf_pkg::cmd_t q_cmd_in, q_cmd_out;

    // payload buffer ports
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [7:0]      wr_data, rd_data;

    // payload hand-off between the two sides
    logic            payload_done, pending;

    // Parse the byte stream; drop bad frames and count them, push one outcome per frame.
    crcdf_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .rx_byte      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd_in),
        .payload_done (payload_done),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .pending      (pending)
    );

    // Hold outcomes so each side may stall on its own.
    crcdf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .full    (q_full),
        .empty   (q_empty),
        .pop     (q_pop),
        .cmd_out (q_cmd_out)
    );

    // Buffer payload bytes of the frame in flight.
    crcdf_store #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Expand each outcome into result transactions.
    crcdf_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (q_cmd_out),
        .q_pop        (q_pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .payload_done (payload_done),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

`ifndef SYNTHESIS
    // the buffer is never overwritten while a payload is still being delivered
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !pending)
        else $error("payload buffer written while delivery pending");

    // an outcome is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("outcome pushed into full queue");

    // error and empty-frame results are single, so always carry last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != crcdf_pkg::EV_PAYLOAD) |-> m_tlast)
        else $error("non-payload result without last");

    // delivery finishing a payload clears the pending mark next cycle
    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        payload_done |=> !pending)
        else $error("pending mark not cleared after payload delivery");
`endif

endmodule

`default_nettype wire

[verif/crc16_frame_deframer_core_tb.sv]
// Self-checking testbench for crc16_frame_deframer_core: byte stream in, frame results out.
// Carries its own deframer predictor and CRC-16 update, and needs only crcdf_pkg and the core.
// Covers a directed header, length and CRC walk, then random frames under several settings.
`default_nettype none

module crc16_frame_deframer_core_tb;

    import crcdf_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int STALL_LIMIT   = 5000;
    // Chance, in percent, that either side idles in a given cycle.
    localparam int IDLE_PERCENT  = 19;
    // Received bytes per random phase, and the number of random phases.
    localparam int PHASE_BYTES   = 86;
    localparam int PHASE_COUNT   = 5;
    localparam int PAYLOAD_LIMIT = PAYLOAD_MAX_DEF;
    // Index outside the register map: the write must be swallowed without effect.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // One result as the block reports it, counters included.
    typedef struct packed {
        event_t      ev;
        logic [7:0]  ftype;
        logic [7:0]  data;
        logic [5:0]  idx;
        logic [6:0]  plen;
        logic        last;
        logic [31:0] good;
        logic [31:0] len_err;
        logic [31:0] crc_err;
        logic [31:0] resync;
    } frame_result_t;

    // How a directed row turns into a byte: literal, or taken from the running CRC.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CRC_BAD
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [7:0]    value;
        logic          pinned;
        frame_result_t outcome;
    } script_row_t;

    // Shapes of random byte sequences.
    typedef enum logic [2:0] {
        SHAPE_GOOD,
        SHAPE_BAD_CRC,
        SHAPE_BAD_LEN,
        SHAPE_MISMATCH,
        SHAPE_NOISE
    } shape_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata   = 8'h00;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [2:0]     cfg_index = REG_HEADER_FIRST;
    logic [15:0]    cfg_data  = 16'h0000;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [159:0]   m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;

    // Register copies held by the predictor.
    logic [7:0]     hdr_a;
    logic [7:0]     hdr_b;
    logic [6:0]     payload_cap;
    logic [15:0]    poly_reg;
    logic [15:0]    init_reg;

    // Parser state held by the predictor.
    phase_t         parse_phase;
    logic [6:0]     len_byte;
    logic [7:0]     type_byte;
    logic [6:0]     taken;
    logic [15:0]    crc_acc;
    logic [7:0]     crc_lo;
    logic [7:0]     payload_buf [PAYLOAD_LIMIT];
    logic [31:0]    n_good;
    logic [31:0]    n_len_err;
    logic [31:0]    n_crc_err;
    logic [31:0]    n_resync;

    frame_result_t  byte_outcomes[$];
    frame_result_t  awaited_results[$];
    script_row_t    script[$];

    int             errors        = 0;
    int             bytes_sent    = 0;
    bit             quiet_stretch = 1'b0;

    always #1 clk = ~clk;

    crc16_frame_deframer_core #(
        .PAYLOAD_MAX (PAYLOAD_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Reflected, LSB-first CRC-16 over one byte with the current polynomial.
    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly_reg;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Append one result for the current byte; counters are taken after their update.
    task automatic queue_outcome(input event_t ev, input logic [7:0] ftype,
                                 input logic [7:0] data, input logic [5:0] idx,
                                 input logic [6:0] plen, input logic last);
        frame_result_t r;
        r.ev      = ev;
        r.ftype   = ftype;
        r.data    = data;
        r.idx     = idx;
        r.plen    = plen;
        r.last    = last;
        r.good    = n_good;
        r.len_err = n_len_err;
        r.crc_err = n_crc_err;
        r.resync  = n_resync;
        byte_outcomes.push_back(r);
    endtask

    // Advance the parser by one received byte and collect the results it releases.
    task automatic deframe_byte(input logic [7:0] b);
        int cap;
        int plen;
        byte_outcomes.delete();
        case (parse_phase)
            PH_HUNT1:
            begin
                if (b == hdr_a)
                    parse_phase = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                // a repeated first header byte keeps the hunt waiting for the second
                if (b == hdr_b)
                begin
                    crc_acc     = init_reg;
                    parse_phase = PH_LEN;
                end
                else if (b != hdr_a)
                    parse_phase = PH_HUNT1;
            end
            PH_LEN:
            begin
                cap = (payload_cap > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : payload_cap;
                if (b == 8'h00 || b > cap + 1)
                begin
                    n_len_err++;
                    n_resync++;
                    parse_phase = PH_HUNT1;
                    queue_outcome(EV_LEN_ERR, 8'h00, 8'h00, 6'd0, 7'd0, 1'b1);
                end
                else
                begin
                    len_byte    = b[6:0];
                    crc_acc     = crc16_update(crc_acc, b);
                    parse_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_byte   = b;
                crc_acc     = crc16_update(crc_acc, b);
                taken       = 7'd0;
                parse_phase = (len_byte <= 1) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA:
            begin
                if (taken < PAYLOAD_LIMIT)
                    payload_buf[taken] = b;
                taken   = taken + 7'd1;
                crc_acc = crc16_update(crc_acc, b);
                if (taken + 1 >= len_byte)
                    parse_phase = PH_CRCLO;
            end
            PH_CRCLO:
            begin
                crc_lo      = b;
                parse_phase = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                parse_phase = PH_HUNT1;
                if ({b, crc_lo} == crc_acc)
                begin
                    n_good++;
                    plen = (len_byte >= 1) ? len_byte - 1 : 0;
                    if (plen > PAYLOAD_LIMIT)
                        plen = PAYLOAD_LIMIT;
                    if (plen == 0)
                        queue_outcome(EV_EMPTY, type_byte, 8'h00, 6'd0, 7'd0, 1'b1);
                    else
                        for (int i = 0; i < plen; i++)
                            queue_outcome(EV_PAYLOAD, type_byte, payload_buf[i], i, plen,
                                          i + 1 == plen);
                end
                else
                begin
                    n_crc_err++;
                    n_resync++;
                    queue_outcome(EV_CRC_ERR, 8'h00, 8'h00, 6'd0, 7'd0, 1'b1);
                end
            end
            default:
            begin
                n_resync++;
                parse_phase = PH_HUNT1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte, idling at random beforehand; predict it at its transaction.
    // Drop the prediction when the caller supplies a typed-in result instead.
    task automatic send_byte(input logic [7:0] b, input bit keep);
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        deframe_byte(b);
        if (keep)
            foreach (byte_outcomes[i])
                awaited_results.push_back(byte_outcomes[i]);
    endtask

    // Write one register and mirror it in the predictor. The caller drops cfg_valid.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_HEADER_FIRST:  hdr_a       = data[7:0];
            REG_HEADER_SECOND: hdr_b       = data[7:0];
            REG_MAX_PAYLOAD:   payload_cap = data[6:0];
            REG_CRC_POLY:      poly_reg    = data;
            REG_CRC_INIT:      init_reg    = data;
            default:           ;
        endcase
    endtask

    // Hold the byte stream, let every awaited result drain, then let the parser settle.
    task automatic settle(input int cycles);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    // Send one random byte sequence of the given shape under the current settings.
    task automatic send_frame(input shape_t shape);
        int         cap;
        int         plen;
        logic [7:0] b;
        logic [7:0] mask;
        bit         hit_lo;
        cap = (payload_cap > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : payload_cap;
        case (shape)
            SHAPE_NOISE:
                repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255), 1'b1);
            SHAPE_MISMATCH:
            begin
                send_byte(hdr_a, 1'b1);
                repeat ($urandom_range(0, 2)) send_byte(hdr_a, 1'b1);
                do
                    b = $urandom_range(0, 255);
                while (b == hdr_a || b == hdr_b);
                send_byte(b, 1'b1);
            end
            default:
            begin
                send_byte(hdr_a, 1'b1);
                // now and then repeat the first header byte before the second
                if ($urandom_range(0, 4) == 0)
                    send_byte(hdr_a, 1'b1);
                send_byte(hdr_b, 1'b1);
                if (shape == SHAPE_BAD_LEN)
                begin
                    b = ($urandom_range(0, 1) == 0) ? 8'h00 : $urandom_range(cap + 2, 255);
                    send_byte(b, 1'b1);
                end
                else
                begin
                    // mostly short payloads, the odd one at the full limit
                    if (cap == 0)
                        plen = 0;
                    else if ($urandom_range(0, 9) == 0)
                        plen = cap;
                    else
                        plen = $urandom_range(0, (cap < 6) ? cap : 6);
                    send_byte(plen + 1, 1'b1);
                    send_byte($urandom_range(0, 255), 1'b1);
                    repeat (plen) send_byte($urandom_range(0, 255), 1'b1);
                    mask   = (shape == SHAPE_BAD_CRC) ? $urandom_range(1, 255) : 8'h00;
                    hit_lo = $urandom_range(0, 1);
                    send_byte(crc_acc[7:0] ^ (hit_lo ? mask : 8'h00), 1'b1);
                    send_byte(crc_acc[15:8] ^ (hit_lo ? 8'h00 : mask), 1'b1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    task automatic add_row(input row_kind_t kind, input logic [7:0] value);
        script_row_t row;
        row        = '0;
        row.kind   = kind;
        row.value  = value;
        script.push_back(row);
    endtask

    // Row whose single error result is typed in: all payload fields zero, last set.
    task automatic add_checked(input row_kind_t kind, input logic [7:0] value,
                               input event_t ev, input logic [31:0] good,
                               input logic [31:0] len_err, input logic [31:0] crc_err,
                               input logic [31:0] resync);
        script_row_t row;
        row                 = '0;
        row.kind            = kind;
        row.value           = value;
        row.pinned          = 1'b1;
        row.outcome.ev      = ev;
        row.outcome.last    = 1'b1;
        row.outcome.good    = good;
        row.outcome.len_err = len_err;
        row.outcome.crc_err = crc_err;
        row.outcome.resync  = resync;
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result stream at random, except during the quiet stretch.
    always @(posedge clk)
        m_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare every result transaction with the oldest awaited one, field by field.
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $error("result with nothing awaited: event_res %0d", m_tuser);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("event_res",       want.ev,      m_tuser);
                check_field("frame_type",      want.ftype,   m_tdata[7:0]);
                check_field("data_byte",       want.data,    m_tdata[15:8]);
                check_field("byte_index",      want.idx,     m_tdata[21:16]);
                check_field("payload_length",  want.plen,    m_tdata[28:22]);
                check_field("last",            want.last,    m_tlast);
                check_field("good_frames",     want.good,    m_tdata[60:29]);
                check_field("length_errors",   want.len_err, m_tdata[92:61]);
                check_field("checksum_errors", want.crc_err, m_tdata[124:93]);
                check_field("resync_total",    want.resync,  m_tdata[156:125]);
            end
        end
    end

    // Count cycles without any transaction; a hung block ends the run here.
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        script_row_t row;
        logic [7:0]  b;
        logic [15:0] junk;
        logic [6:0]  cap_val;
        int          roll;
        int          start_bytes;
        shape_t      shape;

        // Predictor starts from the reset values of the register map.
        hdr_a       = HEADER_FIRST_RST;
        hdr_b       = HEADER_SECOND_RST;
        payload_cap = MAX_PAYLOAD_RST;
        poly_reg    = CRC_POLY_RST;
        init_reg    = CRC_INIT_RST;
        parse_phase = PH_HUNT1;
        len_byte    = 7'd0;
        type_byte   = 8'h00;
        taken       = 7'd0;
        crc_acc     = CRC_INIT_RST;
        crc_lo      = 8'h00;
        n_good      = '0;
        n_len_err   = '0;
        n_crc_err   = '0;
        n_resync    = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk at reset settings: header AA 55, payload up to 64, 0xA001 from 0xFFFF.
        // Repeated first header byte, then a zero length byte.
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h55);
        add_checked(ROW_BYTE, 8'h00, EV_LEN_ERR, 32'd0, 32'd1, 32'd0, 32'd1);
        // Header mismatch returns to the hunt quietly; then a length one above the limit.
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h13);
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h55);
        add_checked(ROW_BYTE, 8'h42, EV_LEN_ERR, 32'd0, 32'd2, 32'd0, 32'd2);
        // Empty frame with type FF.
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h55);
        add_row(ROW_BYTE, 8'h01);
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_CRC_LO, 8'h00);
        add_row(ROW_CRC_HI, 8'h00);
        // One payload byte FF with type 00.
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h55);
        add_row(ROW_BYTE, 8'h02);
        add_row(ROW_BYTE, 8'h00);
        add_row(ROW_BYTE, 8'hFF);
        add_row(ROW_CRC_LO, 8'h00);
        add_row(ROW_CRC_HI, 8'h00);
        // Empty frame with a corrupted CRC high byte.
        add_row(ROW_BYTE, 8'hAA);
        add_row(ROW_BYTE, 8'h55);
        add_row(ROW_BYTE, 8'h01);
        add_row(ROW_BYTE, 8'h7E);
        add_row(ROW_CRC_LO, 8'h00);
        add_checked(ROW_CRC_BAD, 8'h00, EV_CRC_ERR, 32'd2, 32'd2, 32'd1, 32'd3);

        foreach (script[i])
        begin
            row = script[i];
            case (row.kind)
                ROW_BYTE:   b = row.value;
                ROW_CRC_LO: b = crc_acc[7:0];
                ROW_CRC_HI: b = crc_acc[15:8];
                default:    b = ~crc_acc[15:8];
            endcase
            send_byte(b, !row.pinned);
            if (row.pinned)
                awaited_results.push_back(row.outcome);
        end

        // Random phases, each under its own register settings, written while idle.
        // Narrow registers get junk in their unused upper data bits.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle(8);
            junk = $urandom_range(0, 65535);
            case (p)
                0:
                begin
                    // low extremes: only empty frames pass
                    write_reg(REG_HEADER_FIRST,  {junk[15:8], 8'h00});
                    write_reg(REG_HEADER_SECOND, {junk[7:0], 8'hFF});
                    write_reg(REG_MAX_PAYLOAD,   {junk[8:0], 7'd0});
                    write_reg(REG_CRC_POLY,      16'h8408);
                    write_reg(REG_CRC_INIT,      16'h0000);
                    write_reg(REG_UNUSED,        junk);
                end
                1:
                begin
                    // high extremes: payload limit saturates
                    write_reg(REG_HEADER_FIRST,  {junk[15:8], 8'hFF});
                    write_reg(REG_HEADER_SECOND, {junk[7:0], 8'h00});
                    write_reg(REG_MAX_PAYLOAD,   {junk[8:0], 7'h7F});
                    write_reg(REG_CRC_POLY,      16'hFFFF);
                    write_reg(REG_CRC_INIT,      16'hFFFF);
                end
                2:
                begin
                    // both header bytes equal
                    b       = $urandom_range(0, 255);
                    cap_val = $urandom_range(1, 64);
                    write_reg(REG_HEADER_FIRST,  {junk[15:8], b});
                    write_reg(REG_HEADER_SECOND, {junk[7:0], b});
                    write_reg(REG_MAX_PAYLOAD,   {junk[8:0], cap_val});
                    write_reg(REG_CRC_POLY,      $urandom_range(0, 65535));
                    write_reg(REG_CRC_INIT,      $urandom_range(0, 65535));
                end
                3:
                begin
                    write_reg(REG_HEADER_FIRST,  {junk[15:8], 8'($urandom_range(0, 255))});
                    write_reg(REG_HEADER_SECOND, {junk[7:0], 8'($urandom_range(0, 255))});
                    write_reg(REG_MAX_PAYLOAD,   {junk[8:0], 7'd64});
                    write_reg(REG_CRC_POLY,      16'h0000);
                    write_reg(REG_CRC_INIT,      $urandom_range(0, 65535));
                end
                default:
                begin
                    cap_val = $urandom_range(0, 127);
                    write_reg(REG_HEADER_FIRST,  {junk[15:8], 8'($urandom_range(0, 255))});
                    write_reg(REG_HEADER_SECOND, {junk[7:0], 8'($urandom_range(0, 255))});
                    write_reg(REG_MAX_PAYLOAD,   {junk[8:0], cap_val});
                    write_reg(REG_CRC_POLY,      $urandom_range(0, 65535));
                    write_reg(REG_CRC_INIT,      $urandom_range(0, 65535));
                end
            endcase
            cfg_valid <= 1'b0;

            // Hold both sides busy for the whole of the middle phase.
            quiet_stretch = (p == 2);
            start_bytes   = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    shape = SHAPE_GOOD;
                else if (roll < 80)
                    shape = SHAPE_BAD_CRC;
                else if (roll < 88)
                    shape = SHAPE_BAD_LEN;
                else if (roll < 94)
                    shape = SHAPE_MISMATCH;
                else
                    shape = SHAPE_NOISE;
                send_frame(shape);
            end
            quiet_stretch = 1'b0;
        end

        // Drain, then give stray results a chance to show up.
        settle(20);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
